### rtl/clx_pkg.sv
`timescale 1ns / 1ps
package clx_pkg;

    localparam int LEXEME_LIMIT   = 64;
    localparam int POSITION_WIDTH = 16;
    localparam int OFFSET_WIDTH   = 24;
    localparam int LEN_W          = $clog2(LEXEME_LIMIT);
    localparam int ERR_W          = 16;
    localparam int KIND_W         = 6;
    localparam int KW_N           = 9;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
    localparam logic [OFFSET_WIDTH-1:0]   OFF_MAX = '1;
    localparam logic [LEN_W-1:0]          LEN_MAX = LEN_W'(LEXEME_LIMIT - 1);
    localparam logic [ERR_W-1:0]          ERR_MAX = '1;

    // token kinds
    localparam logic [KIND_W-1:0] K_EOF    = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT  = 6'd1;
    localparam logic [KIND_W-1:0] K_INT    = 6'd2;
    localparam logic [KIND_W-1:0] K_FLOAT  = 6'd3;
    localparam logic [KIND_W-1:0] K_KW0    = 6'd4;
    localparam logic [KIND_W-1:0] K_DOT    = 6'd13;
    localparam logic [KIND_W-1:0] K_INC    = 6'd14;
    localparam logic [KIND_W-1:0] K_PLUSEQ = 6'd15;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd16;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd17;
    localparam logic [KIND_W-1:0] K_STAR   = 6'd18;
    localparam logic [KIND_W-1:0] K_SLASH  = 6'd19;
    localparam logic [KIND_W-1:0] K_LE     = 6'd20;
    localparam logic [KIND_W-1:0] K_LT     = 6'd21;
    localparam logic [KIND_W-1:0] K_GE     = 6'd22;
    localparam logic [KIND_W-1:0] K_GT     = 6'd23;
    localparam logic [KIND_W-1:0] K_EQEQ   = 6'd24;
    localparam logic [KIND_W-1:0] K_ASSIGN = 6'd25;
    localparam logic [KIND_W-1:0] K_NE     = 6'd26;
    localparam logic [KIND_W-1:0] K_BANG   = 6'd27;
    localparam logic [KIND_W-1:0] K_AND    = 6'd28;
    localparam logic [KIND_W-1:0] K_OR     = 6'd29;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd30;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd31;
    localparam logic [KIND_W-1:0] K_LBRACK = 6'd32;
    localparam logic [KIND_W-1:0] K_RBRACK = 6'd33;
    localparam logic [KIND_W-1:0] K_LBRACE = 6'd34;
    localparam logic [KIND_W-1:0] K_RBRACE = 6'd35;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd36;
    localparam logic [KIND_W-1:0] K_COLON  = 6'd37;
    localparam logic [KIND_W-1:0] K_SEMI   = 6'd38;

    // byte code 0 marks end of source inside the lexer
    localparam logic [7:0] CH_END = 8'd0;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] column;
        logic [OFFSET_WIDTH-1:0]   offset;
        logic [LEN_W-1:0]          length;
        logic [ERR_W-1:0]          errors;
    } t_token;

    typedef struct packed {
        logic   valid;
        logic   emit;
        logic   item_end;
        t_token tok;
    } t_step;

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] r;
        unique case (k)
            4'd0: r = 3'd3;
            4'd1: r = 3'd5;
            4'd2: r = 3'd4;
            4'd3: r = 3'd2;
            4'd4: r = 3'd4;
            4'd5: r = 3'd5;
            4'd6: r = 3'd6;
            4'd7: r = 3'd5;
            4'd8: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [47:0] s;
        unique case (k)
            4'd0: s = "int   ";
            4'd1: s = "float ";
            4'd2: s = "void  ";
            4'd3: s = "if    ";
            4'd4: s = "else  ";
            4'd5: s = "while ";
            4'd6: s = "return";
            4'd7: s = "input ";
            4'd8: s = "print ";
            default: s = '0;
        endcase
        return (p > 3'd5) ? 8'd0 : s[8*(5 - int'(p)) +: 8];
    endfunction

    function automatic logic [POSITION_WIDTH-1:0] pos_add(
        input logic [POSITION_WIDTH-1:0] v, input logic [1:0] k);
        return (v > POS_MAX - POSITION_WIDTH'(k)) ? POS_MAX : v + POSITION_WIDTH'(k);
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] off_add(
        input logic [OFFSET_WIDTH-1:0] v, input logic [1:0] k);
        return (v > OFF_MAX - OFFSET_WIDTH'(k)) ? OFF_MAX : v + OFFSET_WIDTH'(k);
    endfunction

endpackage

### rtl/c_subset_lexer.sv
`timescale 1ns / 1ps
// Streaming lexer for a small C-like language.
// Input channel: one source byte per request (i_char_code), or an end mark
// (i_end_of_source, or a zero byte). A request is taken when i_valid is high
// and o_stall is low.
// Output channel: one token per request (kind, start line/column/offset,
// length, running error count); o_last_of_run marks the last token caused by
// one input request. A token is taken when o_valid is high and i_stall is low.
// Throughput: bytes stream at one per cycle while each yields at most one
// token and the receiver does not stall. A byte that closes a waiting token
// (identifier, number, '.', '/' or a one-byte operator) is scanned again
// after the token is emitted, a failed exponent replays up to two held
// bytes ahead of the current byte, and when the final step of a request
// emits while an earlier token is held, a separate flush step sends the last
// token out. Each taken byte is registered in the scanner's byte queue, and
// each token is registered in the output stage before it leaves.
// Reset (synchronous, active low) returns the scanner to its start state,
// position 1:1 offset 0, and empties the output stage.
// When the receiver stalls, the output token holds, the scanner stops and
// o_stall stays high until the byte in the scanner is finished.
module c_subset_lexer import clx_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_char_code,
    input  logic                      i_end_of_source,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [KIND_W-1:0]         o_token_kind,
    output logic [POSITION_WIDTH-1:0] o_start_line,
    output logic [POSITION_WIDTH-1:0] o_start_column,
    output logic [OFFSET_WIDTH-1:0]   o_start_offset,
    output logic [LEN_W-1:0]          o_lexeme_length,
    output logic [ERR_W-1:0]          o_error_total,
    output logic                      o_last_of_run
);

    t_step      step;
    t_token     tok;
    logic       can_step;
    logic [7:0] in_byte;

    assign in_byte = i_end_of_source ? CH_END : i_char_code;

    clx_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_byte     (in_byte),
        .o_stall    (o_stall),
        .i_can_step (can_step),
        .o_step     (step)
    );

    clx_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .o_can_step (can_step),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_tok      (tok),
        .o_last     (o_last_of_run)
    );

    assign o_token_kind    = tok.kind;
    assign o_start_line    = tok.line;
    assign o_start_column  = tok.column;
    assign o_start_offset  = tok.offset;
    assign o_lexeme_length = tok.length;
    assign o_error_total   = tok.errors;

endmodule

### rtl/clx_scan.sv
`timescale 1ns / 1ps
module clx_scan import clx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_stall,
    input  logic       i_can_step,
    output t_step      o_step
);

    typedef enum logic [4:0] {
        M_START, M_IDENT, M_INT, M_FRAC, M_DOT, M_EXP_E, M_EXP_SIGN, M_EXP_DIG,
        M_SLASH, M_LINE_CMT, M_BLOCK_CMT, M_BLOCK_STAR,
        M_OP_PLUS, M_OP_LT, M_OP_GT, M_OP_EQ, M_OP_BANG, M_OP_AMP, M_OP_BAR
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [POSITION_WIDTH-1:0] r_line, n_line, r_col, n_col, r_tl, n_tl, r_tc, n_tc;
    logic [OFFSET_WIDTH-1:0]   r_off, n_off, r_to, n_to;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [KW_N-1:0]           r_kw, n_kw;
    logic                      r_float, n_float;
    logic [7:0]                r_held [2];
    logic [7:0]                n_held [2];
    logic [1:0]                r_hcnt, n_hcnt;
    logic [ERR_W-1:0]          r_err, n_err;
    logic [7:0]                r_q [3];
    logic [1:0]                r_qn;

    logic              do_step, accept, item_end;
    logic [7:0]        cc;
    logic [1:0]        adv;
    logic              nl, begin_tok, emit, pop, fail, clear, kw_upd;
    logic [KIND_W-1:0] kind, id_kind;
    logic [KW_N-1:0]   kw_base, kw_next;
    logic [LEN_W-1:0]  kw_idx, base_len;
    logic [LEN_W:0]    len_sum;

    assign cc       = r_q[0];
    assign do_step  = (r_qn != 2'd0) && i_can_step;
    assign item_end = do_step && pop && !fail && (r_qn == 2'd1);
    assign o_stall  = !((r_qn == 2'd0) || item_end);
    assign accept   = i_valid && !o_stall;

    always_comb begin
        id_kind = K_IDENT;
        for (int k = KW_N - 1; k >= 0; k--) begin
            if (r_kw[k] && LEN_W'(kw_len(4'(k))) == r_len) begin
                id_kind = K_KW0 + KIND_W'(k);
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_kw      = r_kw;
        n_float   = r_float;
        n_held    = r_held;
        n_hcnt    = r_hcnt;
        n_err     = r_err;
        adv       = 2'd0;
        nl        = 1'b0;
        begin_tok = 1'b0;
        emit      = 1'b0;
        kind      = K_EOF;
        pop       = 1'b1;
        fail      = 1'b0;
        clear     = 1'b0;
        kw_upd    = 1'b0;
        kw_base   = r_kw;

        unique case (r_mode)
            M_START: begin
                if (cc == CH_END) begin
                    begin_tok = 1'b1;
                    emit      = 1'b1;
                    kind      = K_EOF;
                    clear     = 1'b1;
                end else if (cc == " " || cc == 8'h09 || cc == 8'h0d || cc == 8'h0a) begin
                    adv = 2'd1;
                    nl  = (cc == 8'h0a);
                end else begin
                    begin_tok = 1'b1;
                    adv       = 2'd1;
                    if (alpha_byte(cc)) begin
                        kw_base = '1;
                        kw_upd  = 1'b1;
                        n_mode  = M_IDENT;
                    end else if (digit_byte(cc)) begin
                        n_float = 1'b0;
                        n_mode  = M_INT;
                    end else begin
                        unique case (cc)
                            ".": n_mode = M_DOT;
                            "/": n_mode = M_SLASH;
                            "+": n_mode = M_OP_PLUS;
                            "<": n_mode = M_OP_LT;
                            ">": n_mode = M_OP_GT;
                            "=": n_mode = M_OP_EQ;
                            "!": n_mode = M_OP_BANG;
                            "&": n_mode = M_OP_AMP;
                            "|": n_mode = M_OP_BAR;
                            "-": begin emit = 1'b1; kind = K_MINUS;  end
                            "*": begin emit = 1'b1; kind = K_STAR;   end
                            "(": begin emit = 1'b1; kind = K_LPAREN; end
                            ")": begin emit = 1'b1; kind = K_RPAREN; end
                            "[": begin emit = 1'b1; kind = K_LBRACK; end
                            "]": begin emit = 1'b1; kind = K_RBRACK; end
                            "{": begin emit = 1'b1; kind = K_LBRACE; end
                            "}": begin emit = 1'b1; kind = K_RBRACE; end
                            ",": begin emit = 1'b1; kind = K_COMMA;  end
                            ":": begin emit = 1'b1; kind = K_COLON;  end
                            ";": begin emit = 1'b1; kind = K_SEMI;   end
                            default: n_err = (r_err == ERR_MAX) ? r_err : r_err + 1'b1;
                        endcase
                    end
                end
            end
            M_IDENT: begin
                if (alpha_byte(cc) || digit_byte(cc)) begin
                    kw_upd = 1'b1;
                    adv    = 2'd1;
                end else begin
                    emit   = 1'b1;
                    kind   = id_kind;
                    n_mode = M_START;
                    pop    = 1'b0;
                end
            end
            M_INT, M_FRAC: begin
                if (digit_byte(cc)) begin
                    adv = 2'd1;
                end else if (cc == "." && r_mode == M_INT) begin
                    adv     = 2'd1;
                    n_float = 1'b1;
                    n_mode  = M_FRAC;
                end else if (cc == "e" || cc == "E") begin
                    n_held[0] = cc;
                    n_hcnt    = 2'd1;
                    n_mode    = M_EXP_E;
                end else begin
                    emit   = 1'b1;
                    kind   = r_float ? K_FLOAT : K_INT;
                    n_mode = M_START;
                    pop    = 1'b0;
                end
            end
            M_DOT: begin
                if (digit_byte(cc)) begin
                    adv     = 2'd1;
                    n_float = 1'b1;
                    n_mode  = M_FRAC;
                end else begin
                    emit   = 1'b1;
                    kind   = K_DOT;
                    n_mode = M_START;
                    pop    = 1'b0;
                end
            end
            M_EXP_E, M_EXP_SIGN: begin
                if (r_mode == M_EXP_E && (cc == "+" || cc == "-")) begin
                    n_held[1] = cc;
                    n_hcnt    = 2'd2;
                    n_mode    = M_EXP_SIGN;
                end else if (digit_byte(cc)) begin
                    // commit held exponent bytes plus this digit
                    adv     = r_hcnt + 2'd1;
                    n_hcnt  = 2'd0;
                    n_float = 1'b1;
                    n_mode  = M_EXP_DIG;
                end else begin
                    // back off: emit the number, replay the held bytes
                    emit   = 1'b1;
                    kind   = r_float ? K_FLOAT : K_INT;
                    n_hcnt = 2'd0;
                    n_mode = M_START;
                    pop    = 1'b0;
                    fail   = 1'b1;
                end
            end
            M_EXP_DIG: begin
                if (digit_byte(cc)) begin
                    adv = 2'd1;
                end else begin
                    emit   = 1'b1;
                    kind   = K_FLOAT;
                    n_mode = M_START;
                    pop    = 1'b0;
                end
            end
            M_SLASH: begin
                if (cc == "/") begin
                    adv    = 2'd1;
                    n_mode = M_LINE_CMT;
                end else if (cc == "*") begin
                    adv    = 2'd1;
                    n_mode = M_BLOCK_CMT;
                end else begin
                    emit   = 1'b1;
                    kind   = K_SLASH;
                    n_mode = M_START;
                    pop    = 1'b0;
                end
            end
            M_LINE_CMT: begin
                if (cc == CH_END || cc == 8'h0a) begin
                    n_mode = M_START;
                    pop    = 1'b0;
                end else begin
                    adv = 2'd1;
                end
            end
            M_BLOCK_CMT, M_BLOCK_STAR: begin
                if (cc == CH_END) begin
                    n_mode = M_START;
                    pop    = 1'b0;
                end else begin
                    adv = 2'd1;
                    nl  = (cc == 8'h0a);
                    if (cc == "/" && r_mode == M_BLOCK_STAR) begin
                        n_mode = M_START;
                    end else if (cc == "*") begin
                        n_mode = M_BLOCK_STAR;
                    end else begin
                        n_mode = M_BLOCK_CMT;
                    end
                end
            end
            M_OP_PLUS, M_OP_LT, M_OP_GT, M_OP_EQ, M_OP_BANG: begin
                emit   = 1'b1;
                n_mode = M_START;
                if (r_mode == M_OP_PLUS && cc == "+") begin
                    adv  = 2'd1;
                    kind = K_INC;
                end else if (cc == "=") begin
                    adv = 2'd1;
                    unique case (r_mode)
                        M_OP_PLUS: kind = K_PLUSEQ;
                        M_OP_LT:   kind = K_LE;
                        M_OP_GT:   kind = K_GE;
                        M_OP_EQ:   kind = K_EQEQ;
                        default:   kind = K_NE;
                    endcase
                end else begin
                    pop = 1'b0;
                    unique case (r_mode)
                        M_OP_PLUS: kind = K_PLUS;
                        M_OP_LT:   kind = K_LT;
                        M_OP_GT:   kind = K_GT;
                        M_OP_EQ:   kind = K_ASSIGN;
                        default:   kind = K_BANG;
                    endcase
                end
            end
            M_OP_AMP, M_OP_BAR: begin
                n_mode = M_START;
                if ((r_mode == M_OP_AMP && cc == "&") || (r_mode == M_OP_BAR && cc == "|")) begin
                    adv  = 2'd1;
                    emit = 1'b1;
                    kind = (r_mode == M_OP_AMP) ? K_AND : K_OR;
                end else begin
                    // lone & or |: count it, lex this byte again
                    n_err = (r_err == ERR_MAX) ? r_err : r_err + 1'b1;
                    pop   = 1'b0;
                end
            end
            default: begin
                n_mode = M_START;
                pop    = 1'b0;
            end
        endcase

        kw_idx = begin_tok ? '0 : r_len;
        for (int k = 0; k < KW_N; k++) begin
            kw_next[k] = kw_base[k] && (kw_idx < LEN_W'(kw_len(4'(k))))
                         && (kw_char(4'(k), kw_idx[2:0]) == cc);
        end
        if (kw_upd) begin
            n_kw = kw_next;
        end

        base_len = begin_tok ? '0 : r_len;
        len_sum  = {1'b0, base_len} + (LEN_W + 1)'(adv);
        n_len    = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LEN_W-1:0];
        n_line   = nl ? pos_add(r_line, 2'd1) : r_line;
        n_col    = nl ? POSITION_WIDTH'(1) : pos_add(r_col, adv);
        n_off    = off_add(r_off, adv);
        n_tl     = begin_tok ? r_line : r_tl;
        n_tc     = begin_tok ? r_col  : r_tc;
        n_to     = begin_tok ? r_off  : r_to;

        o_step.valid      = do_step;
        o_step.emit       = emit;
        o_step.item_end   = item_end;
        o_step.tok.kind   = kind;
        o_step.tok.line   = n_tl;
        o_step.tok.column = n_tc;
        o_step.tok.offset = n_to;
        o_step.tok.length = n_len;
        o_step.tok.errors = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_START;
            r_line    <= POSITION_WIDTH'(1);
            r_col     <= POSITION_WIDTH'(1);
            r_off     <= '0;
            r_tl      <= POSITION_WIDTH'(1);
            r_tc      <= POSITION_WIDTH'(1);
            r_to      <= '0;
            r_len     <= '0;
            r_kw      <= '1;
            r_float   <= 1'b0;
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_hcnt    <= '0;
            r_err     <= '0;
            r_qn      <= '0;
        end else begin
            if (do_step) begin
                if (clear) begin
                    r_mode    <= M_START;
                    r_line    <= POSITION_WIDTH'(1);
                    r_col     <= POSITION_WIDTH'(1);
                    r_off     <= '0;
                    r_tl      <= POSITION_WIDTH'(1);
                    r_tc      <= POSITION_WIDTH'(1);
                    r_to      <= '0;
                    r_len     <= '0;
                    r_kw      <= '1;
                    r_float   <= 1'b0;
                    r_held[0] <= '0;
                    r_held[1] <= '0;
                    r_hcnt    <= '0;
                    r_err     <= '0;
                end else begin
                    r_mode  <= n_mode;
                    r_line  <= n_line;
                    r_col   <= n_col;
                    r_off   <= n_off;
                    r_tl    <= n_tl;
                    r_tc    <= n_tc;
                    r_to    <= n_to;
                    r_len   <= n_len;
                    r_kw    <= n_kw;
                    r_float <= n_float;
                    r_held  <= n_held;
                    r_hcnt  <= n_hcnt;
                    r_err   <= n_err;
                end
            end
            if (accept) begin
                r_q[0] <= i_byte;
                r_qn   <= 2'd1;
            end else if (do_step && fail) begin
                // replay held bytes ahead of the current byte
                r_q[0] <= r_held[0];
                if (r_hcnt == 2'd2) begin
                    r_q[1] <= r_held[1];
                    r_q[2] <= cc;
                    r_qn   <= 2'd3;
                end else begin
                    r_q[1] <= cc;
                    r_qn   <= 2'd2;
                end
            end else if (do_step && pop) begin
                r_q[0] <= r_q[1];
                r_q[1] <= r_q[2];
                r_qn   <= r_qn - 2'd1;
            end
        end
    end

endmodule

### rtl/clx_emit.sv
`timescale 1ns / 1ps
module clx_emit import clx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_step  i_step,
    output logic   o_can_step,
    output logic   o_valid,
    input  logic   i_stall,
    output t_token o_tok,
    output logic   o_last
);

    logic   r_out_valid, r_out_last, r_pend_v, r_need_flush;
    t_token r_out, r_pend;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_can_step = out_free && !r_need_flush;
    assign o_valid    = r_out_valid;
    assign o_tok      = r_out;
    assign o_last     = r_out_last;

    // one token is held back so the last one of a request can be flagged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_v     <= 1'b0;
            r_need_flush <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
            if (r_need_flush) begin
                r_out        <= r_pend;
                r_out_last   <= 1'b1;
                r_out_valid  <= 1'b1;
                r_pend_v     <= 1'b0;
                r_need_flush <= 1'b0;
            end else if (i_step.valid) begin
                if (i_step.emit) begin
                    if (r_pend_v) begin
                        r_out        <= r_pend;
                        r_out_last   <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_pend       <= i_step.tok;
                        r_need_flush <= i_step.item_end;
                    end else if (i_step.item_end) begin
                        // only token of the request: send it straight out
                        r_out       <= i_step.tok;
                        r_out_last  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_pend   <= i_step.tok;
                        r_pend_v <= 1'b1;
                    end
                end else if (i_step.item_end && r_pend_v) begin
                    r_out       <= r_pend;
                    r_out_last  <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_pend_v    <= 1'b0;
                end
            end
        end
    end

endmodule

### rtl/clx_chk.sv
`timescale 1ns / 1ps
module clx_chk import clx_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [KIND_W-1:0]         o_token_kind,
    input logic [LEN_W-1:0]          o_lexeme_length,
    input logic                      o_last_of_run
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("token dropped under stall");

    a_hold_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_token_kind))
        else $error("token changed under stall");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_EOF |-> o_last_of_run)
        else $error("EOF not last of its request");

    a_eof_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_EOF |-> o_lexeme_length == '0)
        else $error("EOF with nonzero length");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind c_subset_lexer clx_chk u_clx_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_token_kind    (o_token_kind),
    .o_lexeme_length (o_lexeme_length),
    .o_last_of_run   (o_last_of_run)
);

### tb/sv/c_subset_lexer_tb.sv
`timescale 1ns / 1ps
module c_subset_lexer_tb;
    import clx_pkg::*;

    typedef enum logic [4:0] {
        S_START, S_IDENT, S_INT, S_FRAC, S_DOT, S_EXP_E, S_EXP_SIGN, S_EXP_DIG,
        S_SLASH, S_LINE_CMT, S_BLOCK_CMT, S_BLOCK_STAR,
        S_PLUS, S_LT, S_GT, S_EQ, S_BANG, S_AMP, S_BAR
    } t_scan;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] column;
        logic [OFFSET_WIDTH-1:0]   offset;
        logic [LEN_W-1:0]          length;
        logic [ERR_W-1:0]          errors;
        logic                      last;
    } t_tb_token;

    typedef struct packed {
        logic [7:0] code;
        logic       eos;
    } t_byte_req;

    localparam int END_CH = -1;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [7:0] i_char_code = 8'd0;
    logic i_end_of_source = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_last_of_run;
    logic [KIND_W-1:0] o_token_kind;
    logic [POSITION_WIDTH-1:0] o_start_line, o_start_column;
    logic [OFFSET_WIDTH-1:0] o_start_offset;
    logic [LEN_W-1:0] o_lexeme_length;
    logic [ERR_W-1:0] o_error_total;

    c_subset_lexer u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lexer shadow state
    t_scan                     sh_mode;
    logic [POSITION_WIDTH-1:0] sh_line, sh_col, sh_tline, sh_tcol;
    logic [OFFSET_WIDTH-1:0]   sh_off, sh_toff;
    logic [LEN_W-1:0]          sh_len;
    logic [KW_N-1:0]           sh_kw;
    logic                      sh_float;
    logic [7:0]                sh_held [2];
    int                        sh_nheld;
    logic [ERR_W-1:0]          sh_err;

    t_tb_token expected_tokens[$];
    t_tb_token step_tokens[$];
    t_byte_req pending_bytes[$];

    int errors = 0;
    int bytes_sent = 0;
    int tokens_seen = 0;
    int send_idle_pct = 32;
    int recv_idle_pct = 78;
    int idle_cycles = 0;

    string kw_names[KW_N] = '{"int", "float", "void", "if", "else", "while",
                              "return", "input", "print"};

    function automatic bit alpha_ch(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit digit_ch(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_lexer();
        sh_mode = S_START;
        sh_line = 1; sh_col = 1; sh_off = 0;
        sh_tline = 1; sh_tcol = 1; sh_toff = 0;
        sh_len = 0; sh_kw = '1; sh_float = 0;
        sh_held[0] = 0; sh_held[1] = 0; sh_nheld = 0; sh_err = 0;
    endfunction

    function automatic void advance_pos(int c);
        if (c == "\n") begin
            if (sh_line != POS_MAX) sh_line++;
            sh_col = 1;
        end else if (sh_col != POS_MAX) begin
            sh_col++;
        end
        if (sh_off != OFF_MAX) sh_off++;
        if (sh_len != LEN_MAX) sh_len++;
    endfunction

    function automatic void open_token();
        sh_tline = sh_line; sh_tcol = sh_col; sh_toff = sh_off; sh_len = 0;
    endfunction

    function automatic void push_token(logic [KIND_W-1:0] kind);
        t_tb_token t;
        if (step_tokens.size() >= 4) return;
        t = '{kind, sh_tline, sh_tcol, sh_toff, sh_len, sh_err, 1'b0};
        step_tokens.push_back(t);
    endfunction

    function automatic void bump_error();
        if (sh_err != ERR_MAX) sh_err++;
    endfunction

    function automatic void ident_char(int c);
        string s;
        for (int k = 0; k < KW_N; k++) begin
            s = kw_names[k];
            if (sh_kw[k] && (sh_len >= s.len() || s[sh_len] != c)) sh_kw[k] = 0;
        end
        advance_pos(c);
    endfunction

    function automatic logic [KIND_W-1:0] ident_kind();
        string s;
        for (int k = 0; k < KW_N; k++) begin
            s = kw_names[k];
            if (sh_kw[k] && s.len() == sh_len) return K_KW0 + KIND_W'(k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [KIND_W-1:0] number_kind();
        return sh_float ? K_FLOAT : K_INT;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(int c);
        case (c)
            "-": return K_MINUS;
            "*": return K_STAR;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ",": return K_COMMA;
            ":": return K_COLON;
            ";": return K_SEMI;
            default: return K_EOF;
        endcase
    endfunction

    function automatic void lex_start(int c);
        logic [KIND_W-1:0] k;
        if (c == END_CH) begin
            open_token();
            push_token(K_EOF);
            clear_lexer();
            return;
        end
        if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
            advance_pos(c);
            return;
        end
        open_token();
        if (alpha_ch(c)) begin
            sh_kw = '1;
            ident_char(c);
            sh_mode = S_IDENT;
            return;
        end
        advance_pos(c);
        if (digit_ch(c)) begin
            sh_float = 0;
            sh_mode = S_INT;
            return;
        end
        case (c)
            ".": sh_mode = S_DOT;
            "/": sh_mode = S_SLASH;
            "+": sh_mode = S_PLUS;
            "<": sh_mode = S_LT;
            ">": sh_mode = S_GT;
            "=": sh_mode = S_EQ;
            "!": sh_mode = S_BANG;
            "&": sh_mode = S_AMP;
            "|": sh_mode = S_BAR;
            default: begin
                k = single_kind(c);
                if (k != K_EOF) push_token(k);
                else bump_error();
            end
        endcase
    endfunction

    function automatic void lex_byte(int c);
        int n;
        logic [7:0] b [2];
        case (sh_mode)
            S_START: lex_start(c);
            S_IDENT: begin
                if (alpha_ch(c) || digit_ch(c)) ident_char(c);
                else begin
                    push_token(ident_kind());
                    sh_mode = S_START;
                    lex_byte(c);
                end
            end
            S_INT, S_FRAC: begin
                if (digit_ch(c)) advance_pos(c);
                else if (c == "." && sh_mode == S_INT) begin
                    advance_pos(c);
                    sh_float = 1;
                    sh_mode = S_FRAC;
                end else if (c == "e" || c == "E") begin
                    sh_held[0] = 8'(c);
                    sh_nheld = 1;
                    sh_mode = S_EXP_E;
                end else begin
                    push_token(number_kind());
                    sh_mode = S_START;
                    lex_byte(c);
                end
            end
            S_DOT: begin
                if (digit_ch(c)) begin
                    advance_pos(c);
                    sh_float = 1;
                    sh_mode = S_FRAC;
                end else begin
                    push_token(K_DOT);
                    sh_mode = S_START;
                    lex_byte(c);
                end
            end
            S_EXP_E, S_EXP_SIGN: begin
                if (sh_mode == S_EXP_E && (c == "+" || c == "-")) begin
                    sh_held[1] = 8'(c);
                    sh_nheld = 2;
                    sh_mode = S_EXP_SIGN;
                end else if (digit_ch(c)) begin
                    for (int i = 0; i < sh_nheld; i++) advance_pos(sh_held[i]);
                    sh_nheld = 0;
                    advance_pos(c);
                    sh_float = 1;
                    sh_mode = S_EXP_DIG;
                end else begin
                    // back out the held exponent bytes and lex them again
                    n = sh_nheld;
                    b = sh_held;
                    sh_nheld = 0;
                    push_token(number_kind());
                    sh_mode = S_START;
                    for (int i = 0; i < n; i++) lex_byte(b[i]);
                    lex_byte(c);
                end
            end
            S_EXP_DIG: begin
                if (digit_ch(c)) advance_pos(c);
                else begin
                    push_token(K_FLOAT);
                    sh_mode = S_START;
                    lex_byte(c);
                end
            end
            S_SLASH: begin
                if (c == "/") begin
                    advance_pos(c);
                    sh_mode = S_LINE_CMT;
                end else if (c == "*") begin
                    advance_pos(c);
                    sh_mode = S_BLOCK_CMT;
                end else begin
                    push_token(K_SLASH);
                    sh_mode = S_START;
                    lex_byte(c);
                end
            end
            S_LINE_CMT: begin
                if (c == END_CH || c == "\n") begin
                    sh_mode = S_START;
                    lex_byte(c);
                end else advance_pos(c);
            end
            S_BLOCK_CMT, S_BLOCK_STAR: begin
                if (c == END_CH) begin
                    sh_mode = S_START;
                    lex_byte(c);
                end else begin
                    advance_pos(c);
                    if (c == "/" && sh_mode == S_BLOCK_STAR) sh_mode = S_START;
                    else if (c == "*") sh_mode = S_BLOCK_STAR;
                    else sh_mode = S_BLOCK_CMT;
                end
            end
            S_PLUS: begin
                if (c == "+") begin
                    advance_pos(c);
                    push_token(K_INC);
                    sh_mode = S_START;
                end else lex_pair(c, "=", K_PLUSEQ, K_PLUS);
            end
            S_LT:   lex_pair(c, "=", K_LE, K_LT);
            S_GT:   lex_pair(c, "=", K_GE, K_GT);
            S_EQ:   lex_pair(c, "=", K_EQEQ, K_ASSIGN);
            S_BANG: lex_pair(c, "=", K_NE, K_BANG);
            S_AMP:  lex_pair(c, "&", K_AND, K_EOF);
            S_BAR:  lex_pair(c, "|", K_OR, K_EOF);
            default: begin
                sh_mode = S_START;
                lex_byte(c);
            end
        endcase
    endfunction

    // K_EOF as the single kind means a lone first byte is illegal
    function automatic void lex_pair(int c, int second, logic [KIND_W-1:0] paired,
                                     logic [KIND_W-1:0] single);
        if (c == second) begin
            advance_pos(c);
            push_token(paired);
            sh_mode = S_START;
        end else begin
            if (single == K_EOF) bump_error();
            else push_token(single);
            sh_mode = S_START;
            lex_byte(c);
        end
    endfunction

    function automatic void predict_tokens(t_byte_req r);
        t_tb_token t;
        step_tokens.delete();
        lex_byte((r.eos || r.code == CH_END) ? END_CH : int'(r.code));
        for (int i = 0; i < step_tokens.size(); i++) begin
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back('{s[i], 1'b0});
    endfunction

    function automatic void queue_end(bit zero_byte);
        if (zero_byte) pending_bytes.push_back('{CH_END, 1'b0});
        else pending_bytes.push_back('{8'($urandom_range(1, 255)), 1'b1});
    endfunction

    function automatic string random_fragment();
        string frags[] = '{"int ", "float ", "void", "if(", "else{", "while ", "return;",
                           "input", "print", "x_1 ", "Ab9 ", "inty ", "pr ", "42", "3.14",
                           ".5", "1e10", "2.5E-3", "7e+", "8e", "9E-x", "1.e5 ", ". ",
                           "++", "+=", "+", "-", "*", "/", "<=", "<", ">=", ">", "==",
                           "=", "!=", "!", "&&", "||", "&x", "|y", "(", ")", "[", "]",
                           "{", "}", ",", ":", ";", " ", "\t", "\r\n", "\n",
                           "// note\n", "/* blk ** x */", "/**/", "@", "#", "$"};
        string s;
        byte b;
        case ($urandom_range(0, 9))
            0: begin
                b = 8'($urandom_range(1, 255));
                s = " ";
                s[0] = b;
                return s;
            end
            default: return frags[$urandom_range(0, frags.size() - 1)];
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch token %0d %s: got %0d want %0d", tokens_seen, what, got, want);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_valid || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) bytes_sent++;
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_char_code <= pending_bytes[0].code;
                    i_end_of_source <= pending_bytes[0].eos;
                    predict_tokens(pending_bytes.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_tb_token want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected kind", 32'(o_token_kind), 32'd0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_token_kind !== want.kind)
                        report_mismatch("kind", 32'(o_token_kind), 32'(want.kind));
                    if (o_start_line !== want.line)
                        report_mismatch("line", 32'(o_start_line), 32'(want.line));
                    if (o_start_column !== want.column)
                        report_mismatch("column", 32'(o_start_column), 32'(want.column));
                    if (o_start_offset !== want.offset)
                        report_mismatch("offset", 32'(o_start_offset), 32'(want.offset));
                    if (o_lexeme_length !== want.length)
                        report_mismatch("length", 32'(o_lexeme_length), 32'(want.length));
                    if (o_error_total !== want.errors)
                        report_mismatch("errors", 32'(o_error_total), 32'(want.errors));
                    if (o_last_of_run !== want.last)
                        report_mismatch("last", 32'(o_last_of_run), 32'(want.last));
                end
                tokens_seen++;
            end
        end
    end

    initial begin
        string s;
        clear_lexer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: keywords, numbers, operators, failed exponents, lone & and |
        queue_text("int float void if else while return input print _id9 ");
        queue_end(1'b0);
        queue_text("0 9 1.5 .7 3e9 4E+2 5e-1 6e+; 7ex 8E- . ");
        queue_end(1'b1);
        queue_text("a&b|c&&||++ += + - * / <= < >= > == = != ! ()[]{},:;@");
        queue_end(1'b0);
        // long identifier caps the length; unterminated comment runs to end
        s = "";
        for (int i = 0; i < 70; i++) s = {s, "z"};
        queue_text({s, "\n// c\n/* open *"});
        queue_end(1'b1);
        for (int i = 0; i < 8; i++) pending_bytes.push_back('{8'(8'h80 + i), 1'b0});
        pending_bytes.push_back('{8'hff, 1'b0});
        queue_end(1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
            while (pending_bytes.size() < ((ph == 0) ? 300 : 65)) begin
                queue_text(random_fragment());
                if ($urandom_range(0, 30) == 0) queue_end(1'($urandom_range(0, 1)));
            end
            queue_end(ph[0]);
            wait_drained();
        end
        $display("sent %0d source bytes, checked %0d tokens", bytes_sent, tokens_seen);
        $display("covered keywords, numbers, exponent backtrack, operators, comments");
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
rtl/clx_pkg.sv
rtl/clx_scan.sv
rtl/clx_emit.sv
rtl/c_subset_lexer.sv
rtl/clx_chk.sv
tb/sv/c_subset_lexer_tb.sv
